[rtl/lprt_pkg.sv]
// ----------------------------------------------------------------------------
// lprt_pkg: shared constants for the LRU page reference tracker
// Field widths and default sizes used by the cell row and the top level.
// ----------------------------------------------------------------------------
package lprt_pkg;

  localparam int PAGE_W           = 32;  // page number width
  localparam int CNT_W            = 32;  // hit / miss counter width
  localparam int CAP_REG_W        = 7;   // capacity register width
  localparam int CAPACITY_DEFAULT = 64;  // list entries built

  localparam logic [CAP_REG_W-1:0] CAP_RESET = CAP_REG_W'(64);
  localparam logic [CNT_W-1:0]     CNT_MAX   = {CNT_W{1'b1}};

endpackage

[rtl/lprt_cell.sv]
// ----------------------------------------------------------------------------
// lprt_cell: one recency list position
// Holds one page number, compares it against the lookup key and takes the
// entry of its more recent neighbor when told to shift.
// ----------------------------------------------------------------------------
module lprt_cell
  import lprt_pkg::*;
(
  input  logic              clk,
  input  logic              shift,
  input  logic [PAGE_W-1:0] prev_entry,
  input  logic [PAGE_W-1:0] key,
  output logic [PAGE_W-1:0] entry,
  output logic              match
);

  always_ff @(posedge clk) begin
    if (shift) begin
      entry <= prev_entry;
    end
  end

  assign match = (entry == key);

endmodule

[rtl/lprt_scan.sv]
// ----------------------------------------------------------------------------
// lprt_scan: suffix OR across the cell row
// Bit i of the result is set when any input bit at i or above is set.
// Log-depth doubling scan.
// ----------------------------------------------------------------------------
module lprt_scan #(
  parameter int N = 64
) (
  input  logic [N-1:0] vec,
  output logic [N-1:0] suffix
);

  localparam int LV = (N > 1) ? $clog2(N) : 1;

  logic [LV:0][N-1:0] lvl;

  always_comb begin
    lvl[0] = vec;
    for (int l = 0; l < LV; l++) begin
      for (int i = 0; i < N; i++) begin
        if (i + (1 << l) < N) begin
          lvl[l+1][i] = lvl[l][i] | lvl[l][i + (1 << l)];
        end else begin
          lvl[l+1][i] = lvl[l][i];
        end
      end
    end
  end

  assign suffix = lvl[LV];

endmodule

[rtl/lru_page_reference_tracker.sv]
// ----------------------------------------------------------------------------
// lru_page_reference_tracker: fully associative LRU page reference tracker
// A row of cells holds the recency list, most recent at cell 0. Each item is
// one page reference; hits move the page to the front, misses insert it and
// evict the least recent page once the list is full to the capacity in use.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------
//  input    | start / busy          | page_number
//  result   | done (one-cycle pulse)| hit, evicted_valid, evicted_page,
//           |                       | hit_total, miss_total
//  config   | cfg_wr_en             | cfg_wr_data (capacity_in_use)
//
//  The accept edge compares the page against every cell at once and
//  registers the match row; in the update state the row shifts, the
//  counters update and done is registered. No new item is taken while busy.
//  A new item may be started in the same cycle that done is high.
//  Reset (rst, synchronous): list empty, counters zero, capacity 64.
//  The list entries themselves are not cleared; occupancy masks them.
//  The receiver cannot stall; each result is shown for one cycle only.
//
module lru_page_reference_tracker
  import lprt_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [PAGE_W-1:0]    page_number,
  input  logic                 cfg_wr_en,
  input  logic [CAP_REG_W-1:0] cfg_wr_data,
  output logic                 done,
  output logic                 hit,
  output logic                 evicted_valid,
  output logic [PAGE_W-1:0]    evicted_page,
  output logic [CNT_W-1:0]     hit_total,
  output logic [CNT_W-1:0]     miss_total
);

  // occupancy / capacity width, and a width that holds both it and the register
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > CAP_REG_W) ? CW : CAP_REG_W;
  localparam logic [CW-1:0] ONE = CW'(1);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_UPDATE = 1'b1;

  logic                 state;
  logic [CAP_REG_W-1:0] cap_reg;
  logic [CW-1:0]        occ;

  logic [XW-1:0]        cap_x;
  logic [CW-1:0]        cap_eff;
  logic [CW-1:0]        occ_trim;
  logic                 accept;

  logic [PAGE_W-1:0]    entry [CAPACITY];
  logic [CAPACITY-1:0]  match;
  logic [CAPACITY-1:0]  active;
  logic [CAPACITY-1:0]  shift;
  logic [CAPACITY-1:0]  suffix;
  logic [PAGE_W-1:0]    ev_sel;

  // lookup results held for the update cycle
  logic [PAGE_W-1:0]    page_q;
  logic [CAPACITY-1:0]  match_q;
  logic                 full_q;
  logic [PAGE_W-1:0]    ev_q;

  logic                 hit_now;
  logic [CW-1:0]        occ_next;

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state == ST_UPDATE);

  // Clamp the capacity register: zero acts as one, and anything above the
  // built list size acts as the full list.
  always_comb begin
    cap_x = XW'(cap_reg);
    if (cap_x == '0) begin
      cap_x = XW'(1);
    end else if (cap_x > XW'(CAPACITY)) begin
      cap_x = XW'(CAPACITY);
    end
  end
  assign cap_eff = cap_x[CW-1:0];

  // Entries beyond a lowered capacity drop out silently.
  assign occ_trim = (occ > cap_eff) ? cap_eff : occ;

  // Cell row: cell 0 takes the referenced page, every other cell its
  // more recent neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      lprt_cell u_cell (
        .clk        (clk),
        .shift      (shift[i]),
        .prev_entry (page_q),
        .key        (page_number),
        .entry      (entry[i]),
        .match      (match[i])
      );
    end else begin : g_body
      lprt_cell u_cell (
        .clk        (clk),
        .shift      (shift[i]),
        .prev_entry (entry[i-1]),
        .key        (page_number),
        .entry      (entry[i]),
        .match      (match[i])
      );
    end
    assign active[i] = (CW'(i) < occ_trim);
  end

  // Pick the entry at the last position of the capacity in use; it leaves on a full miss.
  always_comb begin
    ev_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CW'(i) == cap_eff - ONE) begin
        ev_sel = ev_sel | entry[i];
      end
    end
  end

  // On a hit only cells up to the matching one shift; on a miss all do.
  lprt_scan #(
    .N (CAPACITY)
  ) u_scan (
    .vec    (match_q),
    .suffix (suffix)
  );

  assign hit_now = |match_q;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      shift[i] = (state == ST_UPDATE) && (hit_now ? suffix[i] : 1'b1);
    end
  end

  always_comb begin
    if (hit_now) begin
      occ_next = occ_trim;
    end else if (full_q) begin
      occ_next = cap_eff;
    end else begin
      occ_next = occ_trim + ONE;
    end
  end

  // Lookup at accept: hold the page, the match row and the eviction view.
  always_ff @(posedge clk) begin
    if (accept) begin
      page_q  <= page_number;
      match_q <= match & active;
      full_q  <= (occ_trim >= cap_eff);
      ev_q    <= ev_sel;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      hit           <= hit_now;
      evicted_valid <= !hit_now && full_q;
      evicted_page  <= (!hit_now && full_q) ? ev_q : '0;
    end
  end

  // Control: state, occupancy, counters, capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      occ        <= '0;
      hit_total  <= '0;
      miss_total <= '0;
      cap_reg    <= CAP_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_wr_en) begin
        cap_reg <= cfg_wr_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          state <= ST_IDLE;
          done  <= 1'b1;
          occ   <= occ_next;
          if (hit_now) begin
            if (hit_total != CNT_MAX) begin
              hit_total <= hit_total + CNT_W'(1);
            end
          end else begin
            if (miss_total != CNT_MAX) begin
              miss_total <= miss_total + CNT_W'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Pages in the list are unique, so at most one cell can match.
  a_single_match: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) |-> $onehot0(match_q))
    else $error("more than one cell matched the page");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    done |-> !(hit && evicted_valid))
    else $error("eviction reported on a hit");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(CAPACITY))
    else $error("occupancy above list size");

  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_UPDATE))
    else $error("result without an update cycle");

  a_miss_count: assert property (@(posedge clk) disable iff (rst)
    (done && !hit && ($past(miss_total) != CNT_MAX))
      |-> (miss_total == $past(miss_total) + CNT_W'(1)))
    else $error("miss counter did not advance on a miss");

endmodule
